// File: src/utf8_validating_decoder_top_assert.svh
// Assertion helpers for the UTF-8 decoder. Both expect clk and rst in scope.
`ifndef UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define U8VD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8vd: same-cycle check failed");
`define U8VD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8vd: next-cycle check failed");
`else
`define U8VD_ASSERT_IMP(name, ante, cons)
`define U8VD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: src/u8vd_pkg.sv
package u8vd_pkg;

  localparam int unsigned U8VD_CP_W       = 21;
  localparam int unsigned U8VD_QUEUE_DEPTH = 4;

  typedef logic [U8VD_CP_W-1:0] cp_t;
  typedef logic [7:0]           byte_t;
  typedef logic [2:0]           len_t;

  localparam cp_t  REPLACEMENT_RESET = 21'h00FFFD;
  localparam cp_t  CP_MAX            = 21'h10FFFF;
  localparam cp_t  SURROGATE_LO      = 21'h00D800;
  localparam cp_t  SURROGATE_HI      = 21'h00DFFF;
  localparam cp_t  MIN_LEN3          = 21'h000800;
  localparam cp_t  MIN_LEN4          = 21'h010000;
  localparam cp_t  MIN_LEN2          = 21'h000080;
  localparam len_t LEN_NONE          = 3'd0;
  localparam len_t LEN_2             = 3'd2;
  localparam len_t LEN_3             = 3'd3;
  localparam len_t LEN_4             = 3'd4;

  // One queued job: a run of replacements, optionally followed by one
  // plain result (a decoded scalar or the end-of-text marker).
  typedef struct packed {
    len_t reps;
    logic tail;
    logic tail_eot;
    cp_t  tail_cp;
  } job_t;

endpackage

// File: src/u8vd_ifs.sv
interface u8vd_byte_if;
  import u8vd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u8vd_cp_if;
  import u8vd_pkg::*;
  logic valid;
  logic ready;
  cp_t  code_point;
  logic is_replacement;
  logic end_of_text;
  logic last_of_run;
  modport source (output valid, output code_point, output is_replacement,
                  output end_of_text, output last_of_run, input ready);
  modport sink (input valid, input code_point, input is_replacement,
                input end_of_text, input last_of_run, output ready);
endinterface

// File: src/utf8_validating_decoder_top.sv
// Streaming UTF-8 decoder with validation. One byte enters per item on
// byte_chan; each byte gives zero to four code-point items on code_chan,
// the final one of a byte marked by last_of_run. Invalid or cut-short input
// yields replacement_code (reset 0xFFFD, written through cfg_we/cfg_wdata
// while idle, a rule for the user that the block does not enforce),
// flagged by is_replacement; a zero byte flushes any pending sequence and
// ends with an end_of_text item of code point zero. Rate: one byte per
// cycle while the job queue (QueueDepth entries) has room, and one result
// item per cycle on the output while code_chan.ready is high, so bytes
// that give several items let the output port set the sustained rate.
`include "utf8_validating_decoder_top_assert.svh"

module utf8_validating_decoder_top #(
  parameter int unsigned QueueDepth = u8vd_pkg::U8VD_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  u8vd_pkg::cp_t cfg_wdata,
  u8vd_byte_if.sink     byte_chan,
  u8vd_cp_if.source     code_chan
);
  import u8vd_pkg::*;

  cp_t  replacement_code;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  // Hold the replacement code; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_code <= REPLACEMENT_RESET;
    end else if (cfg_we) begin
      replacement_code <= cfg_wdata;
    end
  end

  // Front: track the partial sequence and turn each byte that yields results into a job.
  u8vd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Queue: decouple byte intake from result expansion.
  u8vd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (q_job),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  // Back: expand each job into result items through the output register.
  u8vd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_head           (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .replacement_code (replacement_code),
    .code_chan        (code_chan)
  );

  // Never write a job into a full queue.
  `U8VD_ASSERT_IMP(a_no_push_full, q_push, !q_full)
  // A job pushed into an empty queue is visible next cycle.
  `U8VD_ASSERT_NEXT(a_push_fills, q_push && q_empty, !q_empty)
  // End-of-text items carry code point zero and close the byte's run.
  `U8VD_ASSERT_IMP(a_eot_shape, code_chan.valid && code_chan.end_of_text, code_chan.code_point == '0 && !code_chan.is_replacement && code_chan.last_of_run)
  // Replacement items carry the configured code.
  `U8VD_ASSERT_IMP(a_rep_value, code_chan.valid && code_chan.is_replacement, code_chan.code_point == replacement_code)

endmodule

// File: src/u8vd_front.sv
module u8vd_front (
  input  logic            clk,
  input  logic            rst,
  u8vd_byte_if.sink       byte_chan,
  input  logic            q_full,
  output logic            q_push,
  output u8vd_pkg::job_t  q_job
);
  import u8vd_pkg::*;

  len_t  exp_len;
  len_t  rcv_cnt;
  cp_t   partial;
  len_t  exp_len_next;
  len_t  rcv_cnt_next;
  cp_t   partial_next;

  byte_t b;
  logic  accept;
  logic  is_cont;
  logic  lead_zero;
  logic  lead_ascii;
  logic  lead_bad;
  len_t  lead_len;
  cp_t   lead_pv;
  len_t  cnt_inc;
  cp_t   pv_shift;
  logic  overlong;
  logic  surrogate;
  logic  too_big;
  job_t  job;
  logic  has_job;

  assign b               = byte_chan.byte_in;
  assign byte_chan.ready = !q_full;
  assign accept          = byte_chan.valid && !q_full;
  assign is_cont         = (b[7:6] == 2'b10);

  // Classify the byte as if it opened a new sequence.
  always_comb begin
    lead_zero  = (b == 8'h00);
    lead_ascii = !b[7] && !lead_zero;
    lead_bad   = 1'b0;
    lead_len   = LEN_NONE;
    lead_pv    = '0;
    priority if (!b[7]) begin
      lead_len = LEN_NONE;
    end else if (b[7:5] == 3'b110) begin
      lead_len = LEN_2;
      lead_pv  = cp_t'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_len = LEN_3;
      lead_pv  = cp_t'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_len = LEN_4;
      lead_pv  = cp_t'(b[2:0]);
    end else begin
      lead_bad = 1'b1;
    end
  end

  assign cnt_inc   = rcv_cnt + 3'd1;
  assign pv_shift  = {partial[U8VD_CP_W-7:0], b[5:0]};
  assign overlong  = ((exp_len == LEN_2) && (pv_shift < MIN_LEN2)) ||
                     ((exp_len == LEN_3) && (pv_shift < MIN_LEN3)) ||
                     ((exp_len == LEN_4) && (pv_shift < MIN_LEN4));
  assign surrogate = (pv_shift >= SURROGATE_LO) && (pv_shift <= SURROGATE_HI);
  assign too_big   = (pv_shift > CP_MAX);

  always_comb begin
    job.reps     = lead_bad ? 3'd1 : 3'd0;
    job.tail     = lead_zero || lead_ascii;
    job.tail_eot = lead_zero;
    job.tail_cp  = cp_t'(b);
    exp_len_next = lead_len;
    rcv_cnt_next = (lead_len != LEN_NONE) ? 3'd1 : 3'd0;
    partial_next = lead_pv;
    if (exp_len != LEN_NONE) begin
      if (!is_cont) begin
        // Sequence cut short: flag it, then restart on this byte.
        job.reps = job.reps + 3'd1;
      end else if (cnt_inc >= exp_len) begin
        exp_len_next = LEN_NONE;
        rcv_cnt_next = '0;
        partial_next = '0;
        job.tail_eot = 1'b0;
        job.tail_cp  = pv_shift;
        if (overlong || surrogate || too_big) begin
          job.reps = exp_len;
          job.tail = 1'b0;
        end else begin
          job.reps = '0;
          job.tail = 1'b1;
        end
      end else begin
        exp_len_next = exp_len;
        rcv_cnt_next = cnt_inc;
        partial_next = pv_shift;
        job.reps     = '0;
        job.tail     = 1'b0;
      end
    end
  end

  assign has_job = (job.reps != 3'd0) || job.tail;
  assign q_push  = accept && has_job;
  assign q_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= LEN_NONE;
      rcv_cnt <= '0;
      partial <= '0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      rcv_cnt <= rcv_cnt_next;
      partial <= partial_next;
    end
  end

endmodule

// File: src/u8vd_queue.sv
module u8vd_queue #(
  parameter int unsigned Depth = u8vd_pkg::U8VD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8vd_pkg::job_t  wr_job,
  output logic            full,
  input  logic            pop,
  output u8vd_pkg::job_t  head,
  output logic            empty
);
  import u8vd_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: src/u8vd_back.sv
module u8vd_back (
  input  logic            clk,
  input  logic            rst,
  input  u8vd_pkg::job_t  q_head,
  input  logic            q_empty,
  output logic            q_pop,
  input  u8vd_pkg::cp_t   replacement_code,
  u8vd_cp_if.source       code_chan
);
  import u8vd_pkg::*;

  len_t sent;
  logic out_valid;
  cp_t  out_cp;
  logic out_rep;
  logic out_eot;
  logic out_last;

  logic load;
  logic emit;
  logic rep_phase;
  logic item_last;

  assign load      = !out_valid || code_chan.ready;
  assign emit      = load && !q_empty;
  assign rep_phase = (sent < q_head.reps);
  assign item_last = rep_phase ? ((sent + 3'd1 == q_head.reps) && !q_head.tail) : 1'b1;
  assign q_pop     = emit && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent      <= '0;
    end else begin
      if (load) begin
        out_valid <= emit;
      end
      if (emit) begin
        sent <= item_last ? '0 : sent + 3'd1;
      end
    end
  end

  // Payload: no reset needed, qualified by out_valid.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp   <= rep_phase ? replacement_code : q_head.tail_cp;
      out_rep  <= rep_phase;
      out_eot  <= !rep_phase && q_head.tail_eot;
      out_last <= item_last;
    end
  end

  assign code_chan.valid          = out_valid;
  assign code_chan.code_point     = out_cp;
  assign code_chan.is_replacement = out_rep;
  assign code_chan.end_of_text    = out_eot;
  assign code_chan.last_of_run    = out_last;

endmodule

// File: tb/sv/utf8_validating_decoder_top_test.sv
`timescale 1ns / 1ps

module utf8_validating_decoder_top_test;
  import u8vd_pkg::*;

  // Cycles to let pass after the last expected item before a register write
  // or the final verdict; a byte's first item leaves through the queue and
  // the output register, and a lead byte alone shows nothing at all.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Random bytes per replacement-code setting.
  localparam int unsigned PHASE_BYTES = 76;
  localparam int unsigned NUM_PHASES = 5;
  // Hard stop, far beyond the slowest correct run.
  localparam longint unsigned RUN_LIMIT_NS = 64'd2_000_000;

  // One decoded item as it leaves the block.
  typedef struct packed {
    cp_t  code_point;
    logic is_replacement;
    logic end_of_text;
    logic last_of_run;
  } cp_item_t;

  // One row of the directed table. Rows with typed set carry their single
  // result, read straight off the spec; all other rows go through the
  // decoder model below.
  typedef struct packed {
    byte_t b;
    logic  typed;
    cp_t   cp;
    logic  rep;
    logic  eot;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cp_t  cfg_wdata;

  u8vd_byte_if byte_chan ();
  u8vd_cp_if   code_chan ();

  utf8_validating_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_chan (byte_chan),
    .code_chan (code_chan)
  );

  // Decoder model state: replacement register and the pending sequence.
  cp_t  repl_code;
  len_t seq_len;
  len_t seq_got;
  cp_t  seq_bits;

  // Code points still owed by the block, oldest first.
  cp_item_t cp_due[$];
  // Bytes planned by the random generator but not yet sent.
  byte_t    byte_plan[$];

  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Single-result bytes with nothing pending, at the reset replacement.
    '{8'h00, 1'b1, 21'h0,             1'b0, 1'b1},
    '{8'h41, 1'b1, 21'h41,            1'b0, 1'b0},
    '{8'h7F, 1'b1, 21'h7F,            1'b0, 1'b0},
    '{8'h80, 1'b1, REPLACEMENT_RESET, 1'b1, 1'b0},
    '{8'hBF, 1'b1, REPLACEMENT_RESET, 1'b1, 1'b0},
    '{8'hFF, 1'b1, REPLACEMENT_RESET, 1'b1, 1'b0},
    // Smallest two-byte scalar.
    '{8'hC2, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 1'b0, 1'b0},
    // Largest scalar.
    '{8'hF4, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h8F, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hBF, 1'b0, 21'h0, 1'b0, 1'b0},
    // Overlong two-byte form.
    '{8'hC0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 1'b0, 1'b0},
    // Surrogate.
    '{8'hED, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'hA0, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 1'b0, 1'b0},
    // Above the last scalar.
    '{8'hF4, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h90, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 21'h0, 1'b0, 1'b0},
    // Missing continuation, the offending byte is ASCII.
    '{8'hE2, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h41, 1'b0, 21'h0, 1'b0, 1'b0},
    // End of text with a sequence pending.
    '{8'hC3, 1'b0, 21'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 21'h0, 1'b0, 1'b0}
  };

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Queue one owed item; last_of_run is fixed up once the byte is done.
  task automatic owe_cp(cp_t cp, logic rep, logic eot);
    cp_item_t it;
    it.code_point = cp;
    it.is_replacement = rep;
    it.end_of_text = eot;
    it.last_of_run = 1'b0;
    cp_due.push_back(it);
  endtask

  task automatic drop_sequence();
    seq_len = LEN_NONE;
    seq_got = 3'd0;
    seq_bits = '0;
  endtask

  // Handle a byte with nothing pending: plain result, new lead, or reject.
  task automatic take_lead_byte(byte_t b);
    if (b == 8'h00) begin
      owe_cp('0, 1'b0, 1'b1);
    end else if (b[7] == 1'b0) begin
      owe_cp(cp_t'(b), 1'b0, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      seq_len = LEN_2;
      seq_bits = cp_t'(b[4:0]);
      seq_got = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_len = LEN_3;
      seq_bits = cp_t'(b[3:0]);
      seq_got = 3'd1;
    end else if (b[7:3] == 5'b11110) begin
      seq_len = LEN_4;
      seq_bits = cp_t'(b[2:0]);
      seq_got = 3'd1;
    end else begin
      owe_cp(repl_code, 1'b1, 1'b0);
    end
  endtask

  // Advance the decoder model by one accepted byte and queue what it owes.
  task automatic decode_byte(byte_t b);
    int unsigned n_before;
    cp_t         cp;
    logic        overlong;
    logic        reject;
    n_before = cp_due.size();
    if (seq_len == LEN_NONE) begin
      take_lead_byte(b);
    end else if (b[7:6] != 2'b10) begin
      // Cut short: flush one replacement, then treat the byte as a lead.
      drop_sequence();
      owe_cp(repl_code, 1'b1, 1'b0);
      take_lead_byte(b);
    end else begin
      seq_bits = {seq_bits[14:0], b[5:0]};
      seq_got = seq_got + 3'd1;
      if (seq_got >= seq_len) begin
        cp = seq_bits;
        overlong = (seq_len == LEN_2 && cp < MIN_LEN2) ||
                   (seq_len == LEN_3 && cp < MIN_LEN3) ||
                   (seq_len == LEN_4 && cp < MIN_LEN4);
        reject = overlong || (cp >= SURROGATE_LO && cp <= SURROGATE_HI) || cp > CP_MAX;
        if (reject) begin
          // One replacement per byte of the bad sequence.
          for (int i = 0; i < int'(seq_len); i++) owe_cp(repl_code, 1'b1, 1'b0);
        end else begin
          owe_cp(cp, 1'b0, 1'b0);
        end
        drop_sequence();
      end
    end
    if (cp_due.size() > n_before) cp_due[$].last_of_run = 1'b1;
  endtask

  // Present one byte, after a random gap, and hold until the block takes it.
  // Return at the accepting edge with valid still high.
  task automatic send_byte(byte_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_chan.valid <= 1'b1;
    byte_chan.byte_in <= b;
    do @(posedge clk); while (!byte_chan.ready);
  endtask

  // Drain every owed item, let the block settle, then write the register.
  task automatic write_replacement(cp_t value);
    byte_chan.valid <= 1'b0;
    while (cp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    repl_code = value;
  endtask

  // Append the n-byte encoding of cp; lead bits above the payload are
  // simply cut, so small values give overlong forms.
  task automatic append_utf8(cp_t cp, int n);
    case (n)
      2: begin
        byte_plan.push_back({3'b110, cp[10:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
      3: begin
        byte_plan.push_back({4'b1110, cp[15:12]});
        byte_plan.push_back({2'b10, cp[11:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
      default: begin
        byte_plan.push_back({5'b11110, cp[20:18]});
        byte_plan.push_back({2'b10, cp[17:12]});
        byte_plan.push_back({2'b10, cp[11:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Plan one random sequence: mostly well-formed text, the rest bad forms,
  // cut-short sequences, stray bytes, end-of-text and raw noise.
  task automatic plan_sequence();
    int unsigned kind;
    int unsigned n;
    cp_t         cp;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      byte_plan.push_back(byte_t'($urandom_range(1, 8'h7F)));
    end else if (kind < 40) begin
      append_utf8(cp_t'($urandom_range(21'h80, 21'h7FF)), 2);
    end else if (kind < 55) begin
      cp = cp_t'($urandom_range(21'h800, 21'hFFFF));
      if (cp >= SURROGATE_LO && cp <= SURROGATE_HI) cp = cp ^ 21'h4000;
      append_utf8(cp, 3);
    end else if (kind < 68) begin
      append_utf8(cp_t'($urandom_range(21'h10000, 21'h10FFFF)), 4);
    end else if (kind < 76) begin
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(2, 4);
          cp = cp_t'($urandom_range(0, n == 2 ? 21'h7F : (n == 3 ? 21'h7FF : 21'hFFFF)));
          append_utf8(cp, n);
        end
        1: append_utf8(cp_t'($urandom_range(21'hD800, 21'hDFFF)), 3);
        default: append_utf8(cp_t'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      endcase
    end else if (kind < 85) begin
      // Cut short: drop one or more trailing continuation bytes.
      n = $urandom_range(2, 4);
      append_utf8(cp_t'($urandom_range(0, 21'h1FFFFF)), n);
      repeat ($urandom_range(1, n - 1)) void'(byte_plan.pop_back());
    end else if (kind < 91) begin
      if ($urandom_range(0, 1)) byte_plan.push_back(byte_t'($urandom_range(8'h80, 8'hBF)));
      else byte_plan.push_back(byte_t'($urandom_range(8'hF8, 8'hFF)));
    end else if (kind < 95) begin
      byte_plan.push_back(8'h00);
    end else begin
      byte_plan.push_back(byte_t'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus: reset, directed table, then random phases, one per setting of
  // the replacement register, each opened by a full drain of the output.
  initial begin
    cp_t         phase_codes [NUM_PHASES];
    cp_item_t    it;
    byte_t       b;
    int unsigned sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    byte_chan.valid = 1'b0;
    byte_chan.byte_in = '0;
    repl_code = REPLACEMENT_RESET;
    drop_sequence();
    phase_codes = '{21'h0, 21'h1FFFFF, CP_MAX, cp_t'($urandom_range(0, 21'h1FFFFF)),
                    REPLACEMENT_RESET};

    // Hold reset, then release it once.
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table at the reset replacement code.
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_byte(dir_rows[r].b);
      if (dir_rows[r].typed) begin
        it.code_point = dir_rows[r].cp;
        it.is_replacement = dir_rows[r].rep;
        it.end_of_text = dir_rows[r].eot;
        it.last_of_run = 1'b1;
        cp_due.push_back(it);
      end else begin
        decode_byte(dir_rows[r].b);
      end
    end

    // Random phases. The drain before each write is also the point where
    // the sender holds off until nothing is owed.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_replacement(phase_codes[p]);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        // Switch between idling and back-to-back stretches now and then.
        if (sent % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (byte_plan.size() == 0) plan_sequence();
        b = byte_plan.pop_front();
        send_byte(b);
        decode_byte(b);
        sent++;
      end
    end

    // Drop valid, wait for the last owed item, let the block settle.
    byte_chan.valid <= 1'b0;
    while (cp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && cp_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: stall at random per item, then check each accepted item
  // against the oldest owed one, field by field.
  initial begin
    int unsigned stall;
    cp_item_t    want;
    code_chan.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        code_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      code_chan.ready <= 1'b1;
      do @(posedge clk); while (!code_chan.valid);
      if (cp_due.size() == 0) begin
        report_mismatch("unexpected item", 32'(code_chan.code_point), 32'h0);
      end else begin
        want = cp_due.pop_front();
        if (code_chan.code_point !== want.code_point)
          report_mismatch("code_point", 32'(code_chan.code_point), 32'(want.code_point));
        if (code_chan.is_replacement !== want.is_replacement)
          report_mismatch("is_replacement", 32'(code_chan.is_replacement),
                          32'(want.is_replacement));
        if (code_chan.end_of_text !== want.end_of_text)
          report_mismatch("end_of_text", 32'(code_chan.end_of_text), 32'(want.end_of_text));
        if (code_chan.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(code_chan.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
